// ===== rtl/hlr_pkg.sv =====
// ----------------------------------------------------------------------------
// hlr_pkg
// shared widths, register indexes, mode codes and the command and status
// types between the huber loss controller and datapath
// ----------------------------------------------------------------------------
package hlr_pkg;

  localparam int unsigned MAX_ELEMENTS_DEF = 65536;

  localparam int unsigned VAL_W   = 16;  // pred and target, signed q8.8
  localparam int unsigned DELTA_W = 16;  // threshold, unsigned q8.8
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned B_W     = VAL_W + 1;
  localparam int unsigned PROD_W  = DELTA_W + B_W;
  localparam int unsigned SHIFT   = 9;   // q16.16 down to q.8, halved
  localparam int unsigned LOSS_W  = PROD_W - SHIFT;
  localparam int unsigned TOTAL_W = 40;
  localparam int unsigned DIVC_W  = $clog2(TOTAL_W + 1);

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_DELTA = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE  = CFG_IDX_W'(1);

  localparam logic [DELTA_W-1:0] DELTA_RST = DELTA_W'(256);

  localparam logic [MODE_W-1:0] MODE_NONE = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_SUM  = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_MEAN = MODE_W'(2);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIFF,
    S_SEL,
    S_MUL,
    S_ACC,
    S_FIN,
    S_DIV,
    S_OUT
  } hlr_state_e;

  typedef enum logic [1:0] {
    RES_LOSS,
    RES_TOTAL,
    RES_QUO
  } hlr_res_sel_e;

  typedef struct packed {
    logic         capture;
    logic         diff;
    logic         sel;
    logic         mul;
    logic         acc;
    logic         clear;
    logic         div_start;
    logic         div_step;
    logic         res_load;
    hlr_res_sel_e res_sel;
    logic         load_out;
  } hlr_cmd_t;

  typedef struct packed {
    logic mode_none;
    logic mode_mean;
    logic last;
    logic div_done;
    logic out_free;
  } hlr_status_t;

endpackage

// ===== rtl/huber_loss_reduce_core.sv =====
// ----------------------------------------------------------------------------
// huber_loss_reduce_core: huber loss with none, sum and mean reduction
// one word in flight at a time: the sequencer steps each word through the
//   single multiplier path and the divider
// reset: delta 1.0, mode none, total and count zero, no clearing pass
// ----------------------------------------------------------------------------
module huber_loss_reduce_core #(
  parameter int unsigned MAX_ELEMENTS = hlr_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // config write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [hlr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [hlr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [31:0]                    s_axis_tdata,   // pred_value, target_value
  input  logic                           s_axis_tlast,   // is_last
  // output stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [39:0]                    m_axis_tdata,   // loss_value
  output logic                           m_axis_tuser    // is_reduced
);
  import hlr_pkg::*;

  hlr_cmd_t    cmd;
  hlr_status_t status;

  assign cfg_ready_o = 1'b1;

  hlr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  hlr_datapath #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .pred_i        (s_axis_tdata[VAL_W-1:0]),
    .target_i      (s_axis_tdata[2*VAL_W-1:VAL_W]),
    .last_i        (s_axis_tlast),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_loss_o    (m_axis_tdata),
    .out_reduced_o (m_axis_tuser),
    .cmd_i         (cmd),
    .status_o      (status)
  );

  // one word in flight at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a word is in flight");

  // a result never appears right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
    else $error("output valid too soon after accept");

  // output register is never overwritten while held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!m_axis_tvalid || m_axis_tready))
    else $error("output word overwritten while stalled");

endmodule

// ===== rtl/hlr_ctrl.sv =====
// ----------------------------------------------------------------------------
// hlr_ctrl
// sequencer that walks one word through difference, operand select,
// multiply, accumulate, optional divide and the output register
// ----------------------------------------------------------------------------
module hlr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  hlr_pkg::hlr_status_t status_i,
  output hlr_pkg::hlr_cmd_t    cmd_o
);
  import hlr_pkg::*;

  hlr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_DIFF;
      S_DIFF: state_d = S_SEL;
      S_SEL:  state_d = S_MUL;
      S_MUL:  state_d = S_ACC;
      S_ACC: begin
        if (status_i.mode_none) state_d = S_OUT;
        else if (status_i.last) state_d = S_FIN;
        else state_d = S_IDLE;
      end
      S_FIN: begin
        if (status_i.mode_mean) state_d = S_DIV;
        else state_d = S_OUT;
      end
      S_DIV:  if (status_i.div_done) state_d = S_OUT;
      S_OUT:  if (status_i.out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      S_DIFF: cmd_o.diff = 1'b1;
      S_SEL:  cmd_o.sel  = 1'b1;
      S_MUL:  cmd_o.mul  = 1'b1;
      S_ACC: begin
        if (status_i.mode_none) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = RES_LOSS;
        end else begin
          cmd_o.acc = 1'b1;
        end
      end
      S_FIN: begin
        cmd_o.clear = 1'b1;
        if (status_i.mode_mean) begin
          cmd_o.div_start = 1'b1;
        end else begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = RES_TOTAL;
        end
      end
      S_DIV: begin
        if (status_i.div_done) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = RES_QUO;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_OUT:  cmd_o.load_out = status_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

// ===== rtl/hlr_datapath.sv =====
// ----------------------------------------------------------------------------
// hlr_datapath
// config registers, huber loss arithmetic, saturating accumulator,
// restoring divider for the mean and the output register
// ----------------------------------------------------------------------------
module hlr_datapath #(
  parameter int unsigned MAX_ELEMENTS = hlr_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [hlr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [hlr_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic [hlr_pkg::VAL_W-1:0]        pred_i,
  input  logic [hlr_pkg::VAL_W-1:0]        target_i,
  input  logic                             last_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [hlr_pkg::TOTAL_W-1:0]      out_loss_o,
  output logic                             out_reduced_o,
  input  hlr_pkg::hlr_cmd_t                cmd_i,
  output hlr_pkg::hlr_status_t             status_o
);
  import hlr_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_ELEMENTS + 1);

  logic [DELTA_W-1:0] delta_q;
  logic [MODE_W-1:0]  mode_q;
  logic [VAL_W-1:0]   pred_q, target_q;
  logic               last_q;
  logic [VAL_W-1:0]   d_q, d_d;
  logic [DELTA_W-1:0] a_q, a_d;
  logic [B_W-1:0]     b_q, b_d;
  logic [PROD_W-1:0]  prod_q;
  logic [LOSS_W-1:0]  loss;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [TOTAL_W-1:0] quo_q, quo_d;
  logic [CNT_W-1:0]   rem_q, rem_d;
  logic [CNT_W-1:0]   divisor_q;
  logic [DIVC_W-1:0]  divc_q;
  logic [TOTAL_W-1:0] res_q, res_d;
  logic               res_red_q;
  logic               out_valid_q;
  logic [TOTAL_W-1:0] out_loss_q;
  logic               out_red_q;

  logic [VAL_W:0]     diff;
  logic               le;
  logic [TOTAL_W:0]   sum;
  logic [CNT_W:0]     rem_sh;
  logic               ge;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delta_q <= DELTA_RST;
      mode_q  <= MODE_NONE;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_IDX_DELTA: delta_q <= cfg_data_i[DELTA_W-1:0];
        CFG_IDX_MODE:  mode_q  <= cfg_data_i[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // difference magnitude and operand select
  always_comb begin
    diff = {pred_q[VAL_W-1], pred_q} - {target_q[VAL_W-1], target_q};
    d_d  = diff[VAL_W] ? VAL_W'(-diff) : diff[VAL_W-1:0];
    le   = d_q <= delta_q;
    a_d  = le ? d_q : delta_q;
    b_d  = le ? {1'b0, d_q} : ({d_q, 1'b0} - {1'b0, delta_q});
  end

  assign loss = prod_q[PROD_W-1:SHIFT];

  // saturating accumulate
  always_comb begin
    sum     = {1'b0, total_q} + (TOTAL_W + 1)'(loss);
    total_d = total_q;
    count_d = count_q;
    if (cmd_i.clear) begin
      total_d = '0;
      count_d = '0;
    end else if (cmd_i.acc) begin
      total_d = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
      if (count_q < CNT_W'(MAX_ELEMENTS)) count_d = count_q + CNT_W'(1);
    end
  end

  // one quotient bit per cycle
  always_comb begin
    rem_sh = {rem_q, quo_q[TOTAL_W-1]};
    ge     = rem_sh >= {1'b0, divisor_q};
    rem_d  = ge ? CNT_W'(rem_sh - {1'b0, divisor_q}) : rem_sh[CNT_W-1:0];
    quo_d  = {quo_q[TOTAL_W-2:0], ge};
  end

  always_comb begin
    case (cmd_i.res_sel)
      RES_LOSS:  res_d = TOTAL_W'(loss);
      RES_TOTAL: res_d = total_q;
      RES_QUO:   res_d = quo_q;
      default:   res_d = quo_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pred_q   <= pred_i;
      target_q <= target_i;
      last_q   <= last_i;
    end
    if (cmd_i.diff) d_q <= d_d;
    if (cmd_i.sel) begin
      a_q <= a_d;
      b_q <= b_d;
    end
    if (cmd_i.mul) prod_q <= a_q * b_q;
    if (cmd_i.div_start) begin
      quo_q     <= total_q;
      rem_q     <= '0;
      divisor_q <= count_q;
    end else if (cmd_i.div_step) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
    if (cmd_i.res_load) begin
      res_q     <= res_d;
      res_red_q <= cmd_i.res_sel != RES_LOSS;
    end
    if (cmd_i.load_out) begin
      out_loss_q <= res_q;
      out_red_q  <= res_red_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= '0;
      count_q     <= '0;
      divc_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      total_q <= total_d;
      count_q <= count_d;
      if (cmd_i.div_start) divc_q <= '0;
      else if (cmd_i.div_step) divc_q <= divc_q + DIVC_W'(1);
      if (cmd_i.load_out) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign status_o.mode_none = mode_q == MODE_NONE;
  assign status_o.mode_mean = mode_q == MODE_MEAN;
  assign status_o.last      = last_q;
  assign status_o.div_done  = divc_q == DIVC_W'(TOTAL_W);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign out_loss_o    = out_loss_q;
  assign out_reduced_o = out_red_q;

endmodule

// ===== test/tb_huber_loss_reduce_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_huber_loss_reduce_core
// drives prediction and target pairs through the huber loss core in the none,
// sum and mean reductions over a range of thresholds, predicts every output
// word in the bench and compares it field by field as it leaves the block
// ----------------------------------------------------------------------------
module tb_huber_loss_reduce_core;
  import hlr_pkg::*;

  localparam logic [MODE_W-1:0]  MODE_ALT   = MODE_W'(3);  // decodes as sum
  localparam logic [TOTAL_W-1:0] TOTAL_SAT  = '1;
  localparam int unsigned        COUNT_SAT  = MAX_ELEMENTS_DEF;
  localparam int unsigned        SETTLE_CYC = 60;
  localparam int unsigned        HOLD_CYC   = 400;

  typedef struct packed {
    logic [39:0] loss;
    logic        reduced;
  } loss_word_t;

  typedef enum logic {
    ROW_CFG,
    ROW_WORD
  } row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] cdata;
    logic [15:0]           pred;
    logic [15:0]           tgt;
    logic                  last;
    logic                  typed;
    loss_word_t            want;
  } dir_row_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [31:0]           s_axis_tdata  = '0;  // pred_value, target_value
  logic                  s_axis_tlast  = 1'b0;  // is_last
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [39:0]           m_axis_tdata;  // loss_value
  logic                  m_axis_tuser;  // is_reduced

  // bench copy of the block state
  logic [DELTA_W-1:0] p_delta = DELTA_RST;
  logic [MODE_W-1:0]  p_mode  = MODE_NONE;
  logic [TOTAL_W-1:0] p_total = '0;
  int unsigned        p_count = 0;

  loss_word_t loss_q[$];
  loss_word_t mon_want;
  dir_row_t   dir_rows[$];

  bit          gap_on    = 1'b1;
  bit          hold_arm  = 1'b0;
  bit          hold_req  = 1'b0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;
  int unsigned fail_cnt  = 0;
  int unsigned words_in  = 0;
  int unsigned words_out = 0;
  int unsigned reduced_out = 0;
  int unsigned cfg_writes = 0;

  huber_loss_reduce_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic longint unsigned elem_loss(logic [15:0] p, logic [15:0] t);
    longint          diff;
    longint unsigned d;
    longint unsigned dl;
    diff = longint'($signed(p)) - longint'($signed(t));
    d    = (diff < 0) ? -diff : diff;
    dl   = p_delta;
    if (d <= dl) begin
      return (d * d) >> SHIFT;
    end
    return (dl * (2 * d - dl)) >> SHIFT;
  endfunction

  task automatic huber_predict(input logic [15:0] p, input logic [15:0] t, input logic l,
                               output bit has, output loss_word_t w);
    longint unsigned loss;
    longint unsigned sum;
    loss = elem_loss(p, t);
    has  = 1'b0;
    w    = '0;
    if (p_mode == MODE_NONE) begin
      has       = 1'b1;
      w.loss    = loss[39:0];
      w.reduced = 1'b0;
    end else begin
      sum = longint'(p_total) + loss;
      if (sum > TOTAL_SAT) begin
        sum = TOTAL_SAT;
      end
      p_total = sum[TOTAL_W-1:0];
      if (p_count < COUNT_SAT) begin
        p_count++;
      end
      if (l) begin
        has       = 1'b1;
        w.reduced = 1'b1;
        w.loss    = (p_mode == MODE_MEAN) ? p_total / p_count : p_total;
        p_total   = '0;
        p_count   = 0;
      end
    end
  endtask

  task automatic push_word(input logic [15:0] p, input logic [15:0] t, input logic l,
                           input logic typed, input loss_word_t want);
    bit         has;
    loss_word_t w;
    if (gap_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {t, p};
    s_axis_tlast  = l;
    do @(posedge clk_i); while (!s_axis_tready);
    huber_predict(p, t, l, has, w);
    if (has) begin
      loss_q.push_back(typed ? want : w);
    end
    words_in++;
    @(negedge clk_i);
  endtask

  task automatic wait_drain();
    while (loss_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    s_axis_tvalid = 1'b0;
    wait_drain();
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_IDX_DELTA) begin
      p_delta = val[DELTA_W-1:0];
    end else if (idx == CFG_IDX_MODE) begin
      p_mode = val[MODE_W-1:0];
    end
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic dir_row_t cfg_row(logic [CFG_IDX_W-1:0] i, logic [CFG_DATA_W-1:0] v);
    dir_row_t r;
    r       = '0;
    r.kind  = ROW_CFG;
    r.idx   = i;
    r.cdata = v;
    return r;
  endfunction

  function automatic dir_row_t word_row(logic [15:0] p, logic [15:0] t, logic l,
                                        logic typed, logic [39:0] loss, logic red);
    dir_row_t r;
    r              = '0;
    r.kind         = ROW_WORD;
    r.pred         = p;
    r.tgt          = t;
    r.last         = l;
    r.typed        = typed;
    r.want.loss    = loss;
    r.want.reduced = red;
    return r;
  endfunction

  function automatic logic [15:0] pick_val();
    case ($urandom_range(0, 5))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_random(input logic l);
    logic [15:0] t;
    logic [15:0] p;
    logic [15:0] off;
    t = pick_val();
    case ($urandom_range(0, 2))
      0: p = pick_val();
      1: begin
        off = p_delta + 16'($urandom_range(0, 8)) - 16'd4;
        p   = $urandom_range(0, 1) ? t + off : t - off;
      end
      default: p = t + 16'($urandom_range(0, 511)) - 16'd256;
    endcase
    push_word(p, t, l, 1'b0, '0);
  endtask

  task automatic run_phase(input logic [DELTA_W-1:0] dl, input logic [MODE_W-1:0] md,
                           input int unsigned n);
    int unsigned left;
    int unsigned run_len;
    write_reg(CFG_IDX_DELTA, CFG_DATA_W'(dl));
    write_reg(CFG_IDX_MODE, CFG_DATA_W'(md));
    // hold-off starts once the block is idle so the sender keeps offering
    if (hold_arm) begin
      hold_arm = 1'b0;
      hold_req = 1'b1;
    end
    left = n;
    while (left != 0) begin
      run_len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 24);
      if (run_len > left) begin
        run_len = left;
      end
      for (int unsigned k = 0; k < run_len; k++) begin
        if (md == MODE_NONE) begin
          push_random(1'($urandom_range(0, 1)));
        end else begin
          push_random(k == run_len - 1);
        end
      end
      left -= run_len;
    end
    s_axis_tvalid = 1'b0;
  endtask

  // output side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYC;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready = 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        m_axis_tready = 1'b0;
      end else if (gap_on && $urandom_range(0, 5) == 0) begin
        stall_left    = $urandom_range(0, 9);
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      words_out++;
      if (m_axis_tuser) begin
        reduced_out++;
      end
      if (loss_q.size() == 0) begin
        if (fail_cnt < 10) begin
          $display("unexpected word: loss %0d reduced %0b", m_axis_tdata, m_axis_tuser);
        end
        fail_cnt++;
      end else begin
        mon_want = loss_q.pop_front();
        if (m_axis_tdata !== mon_want.loss || m_axis_tuser !== mon_want.reduced) begin
          if (fail_cnt < 10) begin
            $display("mismatch at word %0d: loss exp %0d got %0d, reduced exp %0b got %0b",
                     words_out - 1, mon_want.loss, m_axis_tdata, mon_want.reduced,
                     m_axis_tuser);
          end
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    #30_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    dir_rows.push_back(word_row(16'h0000, 16'h0000, 1'b0, 1'b1, 40'd0, 1'b0));
    dir_rows.push_back(word_row(16'h0100, 16'h0000, 1'b0, 1'b1, 40'd128, 1'b0));
    dir_rows.push_back(word_row(16'h7fff, 16'h8000, 1'b0, 1'b1, 40'd65407, 1'b0));
    dir_rows.push_back(word_row(16'h8000, 16'h7fff, 1'b1, 1'b1, 40'd65407, 1'b0));
    dir_rows.push_back(word_row(16'h0064, 16'hff9c, 1'b0, 1'b0, '0, 1'b0));
    dir_rows.push_back(cfg_row(CFG_IDX_DELTA, 16'h0000));
    dir_rows.push_back(word_row(16'h0005, 16'h0000, 1'b0, 1'b1, 40'd0, 1'b0));
    dir_rows.push_back(word_row(16'h0000, 16'h0000, 1'b0, 1'b1, 40'd0, 1'b0));
    dir_rows.push_back(cfg_row(CFG_IDX_DELTA, 16'hffff));
    dir_rows.push_back(word_row(16'h7fff, 16'h8000, 1'b0, 1'b1, 40'd8388352, 1'b0));
    dir_rows.push_back(word_row(16'h1234, 16'hedcb, 1'b0, 1'b0, '0, 1'b0));
    dir_rows.push_back(cfg_row(CFG_IDX_DELTA, CFG_DATA_W'(DELTA_RST)));
    dir_rows.push_back(cfg_row(CFG_IDX_MODE, CFG_DATA_W'(MODE_SUM)));
    dir_rows.push_back(word_row(16'h0100, 16'h0000, 1'b0, 1'b0, '0, 1'b0));
    dir_rows.push_back(word_row(16'h0000, 16'h0100, 1'b0, 1'b0, '0, 1'b0));
    dir_rows.push_back(word_row(16'h0200, 16'h0000, 1'b1, 1'b1, 40'd640, 1'b1));
    dir_rows.push_back(word_row(16'h0100, 16'h0000, 1'b1, 1'b1, 40'd128, 1'b1));
    // upper data bits set, low bits select mean
    dir_rows.push_back(cfg_row(CFG_IDX_MODE, 16'hfffe));
    dir_rows.push_back(word_row(16'h0100, 16'h0000, 1'b0, 1'b0, '0, 1'b0));
    dir_rows.push_back(word_row(16'h0200, 16'h0000, 1'b0, 1'b0, '0, 1'b0));
    dir_rows.push_back(word_row(16'h0000, 16'h0000, 1'b1, 1'b1, 40'd170, 1'b1));
    dir_rows.push_back(word_row(16'h0200, 16'h0000, 1'b1, 1'b1, 40'd384, 1'b1));
    dir_rows.push_back(cfg_row(CFG_IDX_MODE, CFG_DATA_W'(MODE_ALT)));
    dir_rows.push_back(word_row(16'h0100, 16'h0000, 1'b0, 1'b0, '0, 1'b0));
    dir_rows.push_back(word_row(16'h0100, 16'h0000, 1'b1, 1'b1, 40'd256, 1'b1));
    // accumulators survive config writes and none-mode words
    dir_rows.push_back(cfg_row(CFG_IDX_MODE, CFG_DATA_W'(MODE_SUM)));
    dir_rows.push_back(word_row(16'h0100, 16'h0000, 1'b0, 1'b0, '0, 1'b0));
    dir_rows.push_back(cfg_row(CFG_IDX_MODE, CFG_DATA_W'(MODE_NONE)));
    dir_rows.push_back(word_row(16'h0100, 16'h0000, 1'b1, 1'b1, 40'd128, 1'b0));
    dir_rows.push_back(cfg_row(CFG_IDX_DELTA, 16'h0200));
    dir_rows.push_back(cfg_row(CFG_IDX_MODE, CFG_DATA_W'(MODE_SUM)));
    dir_rows.push_back(word_row(16'h0100, 16'h0000, 1'b1, 1'b1, 40'd256, 1'b1));

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_reg(dir_rows[i].idx, dir_rows[i].cdata);
      end else begin
        push_word(dir_rows[i].pred, dir_rows[i].tgt, dir_rows[i].last,
                  dir_rows[i].typed, dir_rows[i].want);
      end
    end
    s_axis_tvalid = 1'b0;

    for (int ph = 0; ph < 14; ph++) begin
      logic [DELTA_W-1:0] dl;
      logic [MODE_W-1:0]  md;
      case (ph)
        0:       dl = '0;
        1:       dl = '1;
        2:       dl = DELTA_RST;
        3:       dl = DELTA_W'(1);
        default: dl = $urandom_range(0, 1) ? DELTA_W'($urandom_range(0, 1024))
                                           : DELTA_W'($urandom);
      endcase
      md     = (ph < 8) ? MODE_W'(ph % 4) : MODE_W'($urandom_range(0, 3));
      gap_on = (ph < 11);
      if (ph == 4) begin
        hold_arm = 1'b1;
      end
      run_phase(dl, md, 102);
    end

    wait_drain();
    $display("sent %0d words and %0d register writes, received %0d words (%0d reduced)",
             words_in, cfg_writes, words_out, reduced_out);
    $display("modes none, sum, mean and the spare code, thresholds 0 to 65535, long hold-off");
    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
